// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/kal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kal_pkg;

   // Serial unit sizes
   localparam int MUL_A_W  = 34;               // multiplicand magnitude
   localparam int MUL_B_W  = 32;               // multiplier magnitude, one bit per cycle
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int NUM_W    = PROD_W + 1;       // product plus rounding offset
   localparam int DEN_W    = 33;               // divisor magnitude
   localparam int MUL_CW   = $clog2(MUL_B_W);
   localparam int DIV_CW   = $clog2(NUM_W);

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_ANGLE_NOISE   = 2'd0,
      CSR_BIAS_NOISE    = 2'd1,
      CSR_MEASURE_NOISE = 2'd2
   } csr_idx_type;

   // Filter sequencer states
   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_COMMIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a_mag;
      logic [MUL_B_W-1:0] b_mag;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quo;
   } div_rsp_type;

   // Clamp a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
      logic signed [31:0] r;
      if (v[68:31] == '0 || v[68:31] == '1) begin
         r = v[31:0];
      end else if (v[68]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kal_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier on magnitudes, one multiplier bit per cycle.
module kal_mul (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kal_pkg::mul_req_type req,
   output kal_pkg::mul_rsp_type   rsp
);
   import kal_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MUL_CW-1:0] cnt_ff, cnt_in;
   logic [MUL_A_W:0]  hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;
   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_A_W:0]  sum;

   // Add the multiplicand when the low bit is set, then shift right
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      sum     = hi_ff + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = req.b_mag;
         a_in    = req.a_mag;
      end else if (busy_ff) begin
         hi_in  = {1'b0, sum[MUL_A_W:1]};
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CW'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = {hi_ff[MUL_A_W-1:0], lo_ff};

endmodule

`default_nettype wire

// ----- rtl/core/kal_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider on magnitudes, one quotient bit per cycle.
module kal_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kal_pkg::div_req_type req,
   output kal_pkg::div_rsp_type   rsp
);
   import kal_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/core/angle_bias_kalman_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                         Contents (lowest bits first)
// req      req_tvalid/tready/tdata[79:0] gyro_rate, accel_angle, step_ms
// rsp      rsp_tvalid/tready/tdata[95:0] angle_est, rate_est, bias_est
// csr      csr_we/addr/wdata[30:0]       angle_noise, bias_noise, measure_noise
//
// Each item runs twelve rounded multiply-divide operations, each a serial
// multiply followed by a serial divide, all through one shared multiplier
// and one shared divider; no new item is taken until the result is stored.
// Reset is synchronous; it restores the noise registers and the filter state.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its own result waits for rsp_tready.
module angle_bias_kalman_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // gyro_rate, accel_angle, step_ms, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // angle_est, rate_est, bias_est
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [30:0] csr_wdata
);
   import kal_pkg::*;

   typedef enum logic [3:0] {
      OP_ANG, OP_P00, OP_P01, OP_P11, OP_K0, OP_K1,
      OP_CA, OP_CB, OP_QAA, OP_QAB, OP_QBA, OP_QBB
   } op_type;

   localparam logic signed [33:0] DT_DEN  = 34'sd1000;
   localparam logic signed [33:0] Q_DEN   = 34'sd16777216;
   localparam logic signed [32:0] Q_ONE   = 33'sd16777216;
   localparam logic signed [31:0] COV_ONE = 32'sd16777216;

   function automatic logic signed [31:0] acc_sat(input logic signed [31:0] x,
                                                  input logic signed [67:0] q,
                                                  input logic sub);
      logic signed [68:0] s;
      s = sub ? 69'(x) - 69'(q) : 69'(x) + 69'(q);
      return sat32(s);
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [31:0] gyro_ff, gyro_in, accel_ff, accel_in;
   logic [9:0]         ms_ff, ms_in;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, err_ff, err_in;
   logic [30:0]        an_ff, an_in, bn_ff, bn_in, mn_ff, mn_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic signed [34:0] op_a;
   logic signed [32:0] op_b;
   logic signed [33:0] op_d;
   logic signed [34:0] a_abs;
   logic signed [32:0] b_abs;
   logic signed [33:0] d_abs;
   logic               neg;
   logic signed [33:0] e;
   logic               e_zero;
   logic signed [67:0] quo_s;
   logic signed [31:0] rate;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Operand selection for the current operation
   always_comb begin
      e      = $signed({3'b000, mn_ff}) + 34'(p00_ff);
      e_zero = (e == '0);
      op_a   = '0;
      op_b   = $signed({23'd0, ms_ff});
      op_d   = DT_DEN;
      unique case (op_ff)
         OP_ANG: op_a = 35'(gyro_ff) - 35'(bias_ff);
         OP_P00: op_a = $signed({4'd0, an_ff}) - 35'(ab_ff) - 35'(ba_ff);
         OP_P01: op_a = -35'(bb_ff);
         OP_P11: op_a = $signed({4'd0, bn_ff});
         OP_K0: begin
            op_a = 35'(p00_ff); op_b = Q_ONE; op_d = e;
         end
         OP_K1: begin
            op_a = 35'(p01_ff); op_b = Q_ONE; op_d = e;
         end
         OP_CA: begin
            op_a = 35'(k0_ff); op_b = 33'(err_ff); op_d = Q_DEN;
         end
         OP_CB: begin
            op_a = 35'(k1_ff); op_b = 33'(err_ff); op_d = Q_DEN;
         end
         OP_QAA: begin
            op_a = 35'(k0_ff); op_b = 33'(p00_ff); op_d = Q_DEN;
         end
         OP_QAB: begin
            op_a = 35'(k0_ff); op_b = 33'(p01_ff); op_d = Q_DEN;
         end
         OP_QBA: begin
            op_a = 35'(k1_ff); op_b = 33'(p00_ff); op_d = Q_DEN;
         end
         OP_QBB: begin
            op_a = 35'(k1_ff); op_b = 33'(p01_ff); op_d = Q_DEN;
         end
         default: op_a = '0;
      endcase
      a_abs = op_a[34] ? -op_a : op_a;
      b_abs = op_b[32] ? -op_b : op_b;
      d_abs = op_d[33] ? -op_d : op_d;
      neg   = op_a[34] ^ op_b[32] ^ op_d[33];
      quo_s = neg ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
      rate  = sat32(69'(gyro_ff) - 69'(bias_ff));
   end

   // Requests to the serial units
   assign mul_req.start = (state_ff == ST_MUL_GO);
   assign mul_req.a_mag = a_abs[MUL_A_W-1:0];
   assign mul_req.b_mag = b_abs[MUL_B_W-1:0];
   assign div_req.start = (state_ff == ST_DIV_GO);
   assign div_req.den   = d_abs[DEN_W-1:0];
   assign div_req.num   = {1'b0, mul_rsp.prod} + NUM_W'(d_abs[DEN_W-1:1]);

   kal_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   kal_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // Sequencer, state update and output register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      gyro_in      = gyro_ff;
      accel_in     = accel_ff;
      ms_in        = ms_ff;
      ang_in       = ang_ff;
      bias_in      = bias_ff;
      aa_in        = aa_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      err_in       = err_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      mn_in        = mn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ANGLE_NOISE:   an_in = csr_wdata;
            CSR_BIAS_NOISE:    bn_in = csr_wdata;
            CSR_MEASURE_NOISE: mn_in = csr_wdata;
            default:           an_in = an_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // input stays closed while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               gyro_in  = req_tdata[31:0];
               accel_in = req_tdata[63:32];
               ms_in    = req_tdata[73:64];
               op_in    = OP_ANG;
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO:   state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: if (mul_rsp.done) state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_rsp.done) state_in = ST_COMMIT;
         ST_COMMIT: begin
            unique case (op_ff)
               OP_ANG: ang_in = acc_sat(ang_ff, quo_s, 1'b0);
               OP_P00: aa_in  = acc_sat(aa_ff, quo_s, 1'b0);
               OP_P01: begin
                  ab_in = acc_sat(ab_ff, quo_s, 1'b0);
                  ba_in = acc_sat(ba_ff, quo_s, 1'b0);
               end
               OP_P11: begin
                  bb_in  = acc_sat(bb_ff, quo_s, 1'b0);
                  p00_in = aa_ff;
                  p01_in = ab_ff;
               end
               OP_K0: k0_in = e_zero ? '0 : acc_sat('0, quo_s, 1'b0);
               OP_K1: begin
                  k1_in  = e_zero ? '0 : acc_sat('0, quo_s, 1'b0);
                  err_in = sat32(69'(accel_ff) - 69'(ang_ff));
               end
               OP_CA:  ang_in  = acc_sat(ang_ff, quo_s, 1'b0);
               OP_CB:  bias_in = acc_sat(bias_ff, quo_s, 1'b0);
               OP_QAA: aa_in   = acc_sat(aa_ff, quo_s, 1'b1);
               OP_QAB: ab_in   = acc_sat(ab_ff, quo_s, 1'b1);
               OP_QBA: ba_in   = acc_sat(ba_ff, quo_s, 1'b1);
               OP_QBB: bb_in   = acc_sat(bb_ff, quo_s, 1'b1);
               default: ang_in = ang_ff;
            endcase
            if (op_ff == OP_QBB) begin
               state_in = ST_DONE;
            end else begin
               op_in    = op_type'(op_ff + 4'd1);
               state_in = ST_MUL_GO;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {bias_ff, rate, ang_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANG;
         ang_ff       <= '0;
         bias_ff      <= '0;
         aa_ff        <= COV_ONE;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= COV_ONE;
         an_ff        <= 31'd16777;
         bn_ff        <= 31'd50332;
         mn_ff        <= 31'd8388608;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
         an_ff        <= an_in;
         bn_ff        <= bn_in;
         mn_ff        <= mn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gyro_ff     <= gyro_in;
      accel_ff    <= accel_in;
      ms_ff       <= ms_in;
      p00_ff      <= p00_in;
      p01_ff      <= p01_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/kal_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the filter top level.
module kal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata
);

   // a stalled result transaction keeps its data
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no result is pending right after reset
   `ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid)

   // an accepted item keeps the input closed while it is worked on
   `ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready)

   // no result appears right after an accept into an empty output
   `ASSERT_NEXT(a_rsp_latency, clock, reset, req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid)

endmodule

bind angle_bias_kalman_filter kal_checker u_kal_checker (.*);

`default_nettype wire
